@@ hw/rtl/aesu_pkg.sv @@
package aesu_pkg;

    localparam int ROUND_KEY_WORDS = 60;
    localparam int MAX_ROUNDS = 14;
    localparam int BLOCK_BYTES = 16;

    typedef logic [ROUND_KEY_WORDS-1:0][31:0] rk_array_t;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2
    } key_len_t;

    typedef enum logic [2:0] {
        REG_KEY_WORD0 = 3'd0,
        REG_KEY_WORD1 = 3'd1,
        REG_KEY_WORD2 = 3'd2,
        REG_KEY_WORD3 = 3'd3,
        REG_KEY_LENGTH = 3'd4,
        REG_CHAIN_MODE = 3'd5,
        REG_DIRECTION = 3'd6,
        REG_UNUSED = 3'd7
    } reg_index_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [0:255] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte b of the state sits at bits [127-8b -: 8]; column c holds bytes 4c to 4c+3.
    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] o;
        for (int b = 0; b < BLOCK_BYTES; b++) begin
            o[127-8*b -: 8] = SBOX[s[127-8*b -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
        logic [127:0] o;
        for (int b = 0; b < BLOCK_BYTES; b++) begin
            o[127-8*b -: 8] = INV_SBOX[s[127-8*b -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inverse);
        logic [127:0] o;
        o = s;
        for (int r = 1; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inverse) begin
                    o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
                end else begin
                    o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
                end
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k] = s[127-8*(4*c+k) -: 8];
            end
            for (int r = 0; r < 4; r++) begin
                o[127-8*(4*c+r) -: 8] = xtime(a[r]) ^ xtime(a[(r+1)%4]) ^ a[(r+1)%4]
                                        ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k] = s[127-8*(4*c+k) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                // 14, 11, 13 and 9 times the bytes from row r onward.
                o[127-8*(4*c+r) -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                    ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                    ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                    ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] round_key(input rk_array_t rk, input int r);
        return {rk[4*r], rk[4*r+1], rk[4*r+2], rk[4*r+3]};
    endfunction

endpackage

@@ hw/rtl/aesu_key_expand.sv @@
module aesu_key_expand (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [255:0]        key,
    input  aesu_pkg::key_len_t  key_len,
    output logic                busy,
    output aesu_pkg::rk_array_t round_keys
);
    import aesu_pkg::*;

    logic [31:0] win_reg [8];
    logic [31:0] win_next [8];
    rk_array_t   rk_reg;
    rk_array_t   rk_next;
    logic [5:0]  idx_reg;
    logic [5:0]  idx_next;
    logic [2:0]  mod_reg;
    logic [2:0]  mod_next;
    logic [7:0]  rcon_reg;
    logic [7:0]  rcon_next;
    logic        busy_reg;
    logic        busy_next;

    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic [31:0] prev_word;
    logic [31:0] t;
    logic [31:0] new_word;

    always_comb begin
        case (key_len)
            KEY_128: begin
                nk = 4'd4;
                last_idx = 6'd43;
            end
            KEY_192: begin
                nk = 4'd6;
                last_idx = 6'd51;
            end
            default: begin
                nk = 4'd8;
                last_idx = 6'(ROUND_KEY_WORDS - 1);
            end
        endcase
    end

    // The window holds the last nk schedule words, oldest at entry 0.
    always_comb begin
        prev_word = win_reg[nk[2:0] - 3'd1];
        t = prev_word;
        rcon_next = rcon_reg;
        if (mod_reg == 3'd0) begin
            t = sub_word({prev_word[23:0], prev_word[31:24]}) ^ {rcon_reg, 24'd0};
            rcon_next = xtime(rcon_reg);
        end else if (nk == 4'd8 && mod_reg == 3'd4) begin
            t = sub_word(prev_word);
        end
        new_word = win_reg[0] ^ t;
    end

    always_comb begin
        win_next = win_reg;
        rk_next = rk_reg;
        idx_next = idx_reg;
        mod_next = mod_reg;
        busy_next = busy_reg;
        if (start) begin
            for (int k = 0; k < 8; k++) begin
                win_next[k] = key[255-32*k -: 32];
                rk_next[k] = key[255-32*k -: 32];
            end
            idx_next = {2'd0, nk};
            mod_next = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int k = 0; k < 7; k++) begin
                win_next[k] = win_reg[k+1];
            end
            win_next[nk[2:0] - 3'd1] = new_word;
            rk_next[idx_reg] = new_word;
            idx_next = idx_reg + 6'd1;
            mod_next = (mod_reg == nk[2:0] - 3'd1) ? 3'd0 : mod_reg + 3'd1;
            if (idx_reg == last_idx) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rcon_reg <= 8'h01;
            idx_reg <= 6'd0;
            mod_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            rcon_reg <= start ? 8'h01 : (busy_reg ? rcon_next : rcon_reg);
            idx_reg <= idx_next;
            mod_reg <= mod_next;
        end
        win_reg <= win_next;
        rk_reg <= rk_next;
    end

    assign busy = busy_reg;
    assign round_keys = rk_reg;

endmodule

@@ hw/rtl/aesu_cipher.sv @@
module aesu_cipher (
    input  logic [127:0]        block_in,
    input  logic [127:0]        chain_in,
    input  logic                first_block,
    input  logic                cbc,
    input  logic                decrypt,
    input  aesu_pkg::key_len_t  key_len,
    input  aesu_pkg::rk_array_t round_keys,
    output logic [127:0]        block_out,
    output logic [127:0]        chain_out
);
    import aesu_pkg::*;

    logic [127:0] prev;
    logic [127:0] enc_in;
    logic [127:0] es [MAX_ROUNDS];
    logic [127:0] ds [MAX_ROUNDS];
    logic [127:0] enc_out;
    logic [127:0] dec_out;
    logic [127:0] dec_last;
    int           nr;
    int           kidx;

    always_comb begin
        case (key_len)
            KEY_128: nr = 10;
            KEY_192: nr = 12;
            default: nr = 14;
        endcase
    end

    assign prev = first_block ? 128'd0 : chain_in;
    assign enc_in = cbc ? (block_in ^ prev) : block_in;

    always_comb begin
        es[0] = enc_in ^ round_key(round_keys, 0);
        for (int r = 1; r < MAX_ROUNDS; r++) begin
            es[r] = mix_columns(shift_rows(sub_bytes(es[r-1]), 1'b0))
                    ^ round_key(round_keys, r);
        end
        case (key_len)
            KEY_128: enc_out = shift_rows(sub_bytes(es[9]), 1'b0) ^ round_key(round_keys, 10);
            KEY_192: enc_out = shift_rows(sub_bytes(es[11]), 1'b0) ^ round_key(round_keys, 12);
            default: enc_out = shift_rows(sub_bytes(es[13]), 1'b0) ^ round_key(round_keys, 14);
        endcase
    end

    // Decryption walks the schedule downward from the last round key.
    always_comb begin
        kidx = 0;
        ds[0] = block_in ^ round_key(round_keys, nr);
        for (int j = 1; j < MAX_ROUNDS; j++) begin
            kidx = (nr - j < 0) ? 0 : nr - j;
            ds[j] = inv_mix_columns(inv_sub_bytes(shift_rows(ds[j-1], 1'b1))
                    ^ round_key(round_keys, kidx));
        end
        case (key_len)
            KEY_128: dec_last = ds[9];
            KEY_192: dec_last = ds[11];
            default: dec_last = ds[13];
        endcase
        dec_out = inv_sub_bytes(shift_rows(dec_last, 1'b1)) ^ round_key(round_keys, 0);
    end

    assign block_out = decrypt ? (cbc ? (dec_out ^ prev) : dec_out) : enc_out;
    assign chain_out = decrypt ? block_in : enc_out;

endmodule

@@ hw/rtl/aes_block_cipher_ecb_cbc_unit.sv @@
// One item per cycle while the result side is not stalled and no key expansion runs.
// Each item is registered, the full cipher runs in one pass of logic, and the result
// is registered; the CBC chain is updated in the same cycle so the next item follows at once.
// Reset or a write to any register but REG_UNUSED starts a key expansion (one schedule
// word per cycle), during which no item is accepted.
// Reset is synchronous and active low; it clears the registers, the chain and the handshakes.
module aes_block_cipher_ecb_cbc_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_hi,
    input  logic [63:0] s_data_lo,
    input  logic        s_first_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_hi,
    output logic [63:0] m_out_lo
);
    import aesu_pkg::*;

    // Configuration registers.
    logic [63:0]  key_word_reg [4];
    key_len_t     key_len_reg;
    logic         chain_mode_reg;
    logic         direction_reg;
    logic         rekey_reg;

    // Input stage, chain and result stage.
    logic         in_valid_reg;
    logic [127:0] in_data_reg;
    logic         in_first_reg;
    logic [127:0] chain_reg;
    logic         out_valid_reg;
    logic [127:0] out_data_reg;

    logic         key_busy;
    rk_array_t    round_keys;
    logic [127:0] result;
    logic [127:0] chain_next;
    logic         out_free;
    logic         fire;
    logic         s_accept;
    key_len_t     wr_len;

    // A length code of 3 is taken as a 256-bit key.
    always_comb begin
        case (key_len_t'(cfg_wdata[1:0]))
            KEY_128: wr_len = KEY_128;
            KEY_192: wr_len = KEY_192;
            default: wr_len = KEY_256;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                key_word_reg[k] <= 64'd0;
            end
            key_len_reg <= KEY_128;
            chain_mode_reg <= 1'b0;
            direction_reg <= 1'b0;
            rekey_reg <= 1'b1;
        end else begin
            rekey_reg <= 1'b0;
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_KEY_WORD0: key_word_reg[0] <= cfg_wdata;
                    REG_KEY_WORD1: key_word_reg[1] <= cfg_wdata;
                    REG_KEY_WORD2: key_word_reg[2] <= cfg_wdata;
                    REG_KEY_WORD3: key_word_reg[3] <= cfg_wdata;
                    REG_KEY_LENGTH: key_len_reg <= wr_len;
                    REG_CHAIN_MODE: chain_mode_reg <= cfg_wdata[0];
                    REG_DIRECTION: direction_reg <= cfg_wdata[0];
                    default: ;
                endcase
                // A write to any listed register schedules a fresh key expansion.
                if (reg_index_t'(cfg_index) != REG_UNUSED) begin
                    rekey_reg <= 1'b1;
                end
            end
        end
    end

    aesu_key_expand u_key_expand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (rekey_reg),
        .key        ({key_word_reg[0], key_word_reg[1], key_word_reg[2], key_word_reg[3]}),
        .key_len    (key_len_reg),
        .busy       (key_busy),
        .round_keys (round_keys)
    );

    aesu_cipher u_cipher (
        .block_in    (in_data_reg),
        .chain_in    (chain_reg),
        .first_block (in_first_reg),
        .cbc         (chain_mode_reg),
        .decrypt     (direction_reg),
        .key_len     (key_len_reg),
        .round_keys  (round_keys),
        .block_out   (result),
        .chain_out   (chain_next)
    );

    // The input stage moves into the result register whenever that register is free
    // or being emptied in the same cycle, so a result that is being read never holds back the input.
    assign out_free = !out_valid_reg || m_ready;
    assign fire = in_valid_reg && out_free;
    assign s_ready = !key_busy && !rekey_reg && (!in_valid_reg || out_free);
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg <= 128'd0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                chain_reg <= chain_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            in_data_reg <= {s_data_hi, s_data_lo};
            in_first_reg <= s_first_block;
        end
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_out_hi = out_data_reg[127:64];
    assign m_out_lo = out_data_reg[63:0];

endmodule

@@ verif/aes_ecb_cbc_checker.sv @@
`default_nettype none

// Watches the configuration port and both item channels, keeps its own copy of the
// cipher state and checks every result block against the predicted one.
module aes_ecb_cbc_checker
    import aesu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [63:0] s_data_hi,
    input  wire logic [63:0] s_data_lo,
    input  wire logic        s_first_block,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [63:0] m_out_hi,
    input  wire logic [63:0] m_out_lo,
    output int               fail_count,
    output int               blocks_due,
    output int               blocks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [63:0]  key_reg [4];
    logic [1:0]   key_len;
    logic         cbc_on;
    logic         decrypt_on;
    logic [127:0] prev_cipher;
    logic [31:0]  sched [ROUND_KEY_WORDS];
    int           rounds;
    logic [127:0] block_queue [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    // The S-box is built from the field inverse and the affine map.
    initial begin
        logic [7:0] inv_val;
        for (int x = 0; x < 256; x++) begin
            inv_val = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gf_mul(8'(x), 8'(y)) == 8'h01) inv_val = 8'(y);
            end
            fwd_sub[x] = inv_val ^ rotl8(inv_val, 1) ^ rotl8(inv_val, 2)
                         ^ rotl8(inv_val, 3) ^ rotl8(inv_val, 4) ^ 8'h63;
        end
        for (int x = 0; x < 256; x++) inv_sub[fwd_sub[x]] = 8'(x);
    end

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int b);
        return s[127-8*b -: 8];
    endfunction

    function automatic logic [31:0] word_sub(input logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    task automatic build_schedule();
        int         nk;
        logic [7:0] rc;
        logic [31:0] t;
        nk = (key_len == KEY_128) ? 4 : (key_len == KEY_192) ? 6 : 8;
        rounds = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < 4 * (rounds + 1); i++) begin
            if (i < nk) begin
                sched[i] = (i % 2 == 0) ? key_reg[i/2][63:32] : key_reg[i/2][31:0];
            end else begin
                t = sched[i-1];
                if (i % nk == 0) begin
                    t = word_sub({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = gf_mul(rc, 8'h02);
                end else if (nk > 6 && i % nk == 4) begin
                    t = word_sub(t);
                end
                sched[i] = sched[i-nk] ^ t;
            end
        end
    endtask

    function automatic logic [127:0] with_key(input logic [127:0] s, input int r);
        return s ^ {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
    endfunction

    function automatic logic [127:0] subst(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        for (int b = 0; b < 16; b++) begin
            o[127-8*b -: 8] = inv ? inv_sub[byte_at(s, b)] : fwd_sub[byte_at(s, b)];
        end
        return o;
    endfunction

    // Byte of row r and column c sits at index 4c + r.
    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        o = s;
        for (int r = 1; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) o[127-8*(r+4*((c+r)%4)) -: 8] = byte_at(s, r + 4*c);
                else o[127-8*(r+4*c) -: 8] = byte_at(s, r + 4*((c+r)%4));
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input bit inv);
        logic [7:0]   coef [4];
        logic [7:0]   acc;
        logic [127:0] o;
        if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++) acc ^= gf_mul(byte_at(s, 4*c+j), coef[(j+4-r)%4]);
                o[127-8*(4*c+r) -: 8] = acc;
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] cipher_block(input logic [127:0] s);
        s = with_key(s, 0);
        for (int r = 1; r <= rounds; r++) begin
            s = rotate_rows(subst(s, 0), 0);
            if (r != rounds) s = mix(s, 0);
            s = with_key(s, r);
        end
        return s;
    endfunction

    function automatic logic [127:0] decipher_block(input logic [127:0] s);
        s = with_key(s, rounds);
        for (int r = rounds; r > 0; r--) begin
            s = with_key(subst(rotate_rows(s, 1), 1), r - 1);
            if (r != 1) s = mix(s, 1);
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at %0t: got %016h, expected %016h", what, $realtime, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [127:0] in_blk, iv, res, want;
        if (!aresetn) begin
            key_reg = '{default: 64'h0};
            key_len = KEY_128;
            cbc_on = 1'b0;
            decrypt_on = 1'b0;
            prev_cipher = '0;
            block_queue.delete();
            build_schedule();
        end else begin
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_KEY_WORD0, REG_KEY_WORD1,
                    REG_KEY_WORD2, REG_KEY_WORD3: key_reg[cfg_index[1:0]] = cfg_wdata;
                    REG_KEY_LENGTH: key_len = cfg_wdata[1:0];
                    REG_CHAIN_MODE: cbc_on = cfg_wdata[0];
                    REG_DIRECTION:  decrypt_on = cfg_wdata[0];
                    default: ;
                endcase
                build_schedule();
            end
            if (s_valid && s_ready) begin
                in_blk = {s_data_hi, s_data_lo};
                iv = s_first_block ? 128'h0 : prev_cipher;
                if (decrypt_on) begin
                    res = decipher_block(in_blk);
                    if (cbc_on) res ^= iv;
                    prev_cipher = in_blk;
                end else begin
                    res = cipher_block(cbc_on ? in_blk ^ iv : in_blk);
                    prev_cipher = res;
                end
                block_queue.push_back(res);
            end
            if (m_valid && m_ready) begin
                if (block_queue.size() == 0) begin
                    $display("MISMATCH unexpected result at %0t: %016h %016h",
                             $realtime, m_out_hi, m_out_lo);
                    fail_count++;
                end else begin
                    want = block_queue.pop_front();
                    if (m_out_hi !== want[127:64]) report_mismatch("out_hi", m_out_hi, want[127:64]);
                    if (m_out_lo !== want[63:0]) report_mismatch("out_lo", m_out_lo, want[63:0]);
                    blocks_checked++;
                end
            end
        end
        blocks_due = block_queue.size();
    end

    initial begin
        fail_count = 0;
        blocks_due = 0;
        blocks_checked = 0;
    end

endmodule

`default_nettype wire

@@ verif/tb_aes_block_cipher_ecb_cbc_unit.sv @@
`default_nettype none

// Stimulus and verdict for the AES ECB/CBC unit. The checker beside the block
// does all prediction; this module only drives items, configuration and stalls.
module tb_aes_block_cipher_ecb_cbc_unit;
    import aesu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_data_hi;
    logic [63:0] s_data_lo;
    logic        s_first_block;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_out_hi;
    logic [63:0] m_out_lo;

    int fail_count;
    int blocks_due;
    int blocks_checked;
    int blocks_sent;
    int settings_run;
    bit sender_busy;  // When set, the sender never idles.
    bit sink_busy;    // When set, the receiver starts no new stall.

    aes_block_cipher_ecb_cbc_unit u_dut (.*);

    aes_ecb_cbc_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver holds m_ready low for random stretches on its own.
    initial begin
        int hold;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (!sink_busy && $urandom_range(0, 99) < 25) begin
                hold = pick_gap();
                m_ready <= (hold == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Lowers valid so the last item is not offered again and waits until every result
    // has come back, so that no item is still in flight when the configuration changes.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (blocks_due != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Writes every register; the narrow ones get random junk above their width.
    task automatic set_mode(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [1:0] klen, input logic chain, input logic dir);
        drain();
        write_reg(REG_KEY_WORD0, k0);
        write_reg(REG_KEY_WORD1, k1);
        write_reg(REG_KEY_WORD2, k2);
        write_reg(REG_KEY_WORD3, k3);
        write_reg(REG_KEY_LENGTH, {$urandom, $urandom} & ~64'h3 | klen);
        write_reg(REG_CHAIN_MODE, {$urandom, $urandom} & ~64'h1 | chain);
        write_reg(REG_DIRECTION, {$urandom, $urandom} & ~64'h1 | dir);
        if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
        settings_run++;
    endtask

    // Presents one item and returns once it has been taken. Valid stays up across
    // back-to-back items and is only lowered when a gap follows.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic first);
        int gap;
        gap = sender_busy ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_hi <= hi;
        s_data_lo <= lo;
        s_first_block <= first;
        // s_ready is sampled on the falling edge, before the clock edge, so that the sample is settled.
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        blocks_sent++;
    endtask

    task automatic quiet_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Data with the extremes and sparse patterns mixed into random words.
    function automatic logic [63:0] rand_data();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    // A random chain of blocks: CBC streams start with a first-marked item and
    // only occasionally restart in the middle.
    task automatic random_stream(input int count);
        for (int i = 0; i < count; i++) begin
            send_block(rand_data(), rand_data(), (i == 0) || ($urandom_range(0, 19) == 0));
        end
    endtask

    initial begin
        logic [1:0] klen;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_WORD0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data_hi = '0;
        s_data_lo = '0;
        s_first_block = 1'b0;
        sender_busy = 1'b0;
        sink_busy = 1'b0;
        blocks_sent = 0;
        settings_run = 0;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: all-zero 128-bit key, ECB, encrypt. The first items run
        // with the extremes of the block and with first_block both ways.
        send_block(64'h0, 64'h0, 1'b0);
        send_block('1, '1, 1'b1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_block(64'h8000000000000000, 64'h0000000000000001, 1'b1);

        // The FIPS-197 example key in every length and mode, with the extremes of the data.
        for (int m = 0; m < 8; m++) begin
            klen = (m < 3) ? 2'(m) : (m == 3) ? 2'd3 : 2'($urandom_range(0, 2));
            set_mode(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                     64'h1011121314151617, 64'h18191a1b1c1d1e1f,
                     klen, m[0] ^ m[2], m[1]);
            send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
            send_block(64'h0, 64'h0, 1'b0);
            send_block('1, '1, 1'b0);
        end

        // Extreme key: all ones, every length including code 3.
        for (int m = 0; m < 4; m++) begin
            set_mode('1, '1, '1, '1, 2'(m), 1'b1, m[0]);
            random_stream(25);
        end

        // Random keys and modes; some settings run with no idling on either side.
        for (int p = 0; p < 24; p++) begin
            set_mode(rand64(), rand64(), rand64(), rand64(), 2'($urandom_range(0, 3)),
                     1'($urandom), 1'($urandom));
            sender_busy = ($urandom_range(0, 3) == 0);
            sink_busy = sender_busy && $urandom_range(0, 1);
            random_stream(30);
            // Once, the sender holds off until every result is back.
            if (p == 5) begin
                quiet_sender();
                drain();
            end
            random_stream(30);
            sender_busy = 1'b0;
            sink_busy = 1'b0;
        end
        quiet_sender();

        @(posedge aclk);
        while (blocks_due != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d blocks and checked %0d results over %0d key and mode settings,",
                 blocks_sent, blocks_checked, settings_run);
        $display("covering all key lengths, ECB and CBC, encrypt and decrypt.");
        if (fail_count == 0 && blocks_due == 0) begin
            $display("** aes_block_cipher_ecb_cbc_unit: PASSED **");
        end else begin
            $display("** aes_block_cipher_ecb_cbc_unit: FAILED **");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding.", blocks_due);
        $display("** aes_block_cipher_ecb_cbc_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
